### rtl/jhs_pkg.sv
// jhs_pkg: shared types and constants for the jump history stack.
// Depends on nothing; used by jhs_cell, jump_history_stack and jhs_checker.
package jhs_pkg;

    localparam int DEPTH_DEF = 16;      // default number of history cells
    localparam int BUF_W     = 6;       // buffer id width
    localparam int POS_W     = 24;      // position width
    localparam int MASK_W    = 64;      // one alive bit per buffer id
    localparam int MODE_W    = 2;
    localparam int CNT_OUT_W = 5;       // width of cursor and fill outputs

    // Operation codes carried on the mode input.
    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH  = 2'd0,
        MODE_OLDER = 2'd1,
        MODE_NEWER = 2'd2
    } t_mode;

    // One history entry: equality compares both fields.
    typedef struct packed {
        logic [BUF_W-1:0] buffer;
        logic [POS_W-1:0] position;
    } t_entry;

    // Per-cell write control from the sequencer.
    typedef struct packed {
        logic load;     // take the write data
        logic shift;    // take the neighbor's entry (oldest entry drops out)
    } t_cell_ctrl;

endpackage

### rtl/jhs_cell.sv
// jhs_cell: one history slot of the chain; holds an entry, shifts from its
// newer neighbor, and flags equality and liveness locally. Uses jhs_pkg.
module jhs_cell (
    input  logic                       i_clk,
    input  jhs_pkg::t_cell_ctrl        i_ctrl,
    input  jhs_pkg::t_entry            i_nbr,
    input  jhs_pkg::t_entry            i_wdata,
    input  jhs_pkg::t_entry            i_cmp,
    input  logic [jhs_pkg::MASK_W-1:0] i_mask,
    input  logic                       i_check,
    output jhs_pkg::t_entry            o_entry,
    output logic                       o_eq,
    output logic                       o_alive
);
    import jhs_pkg::*;

    t_entry r_entry;

    // Load wins over shift: the top cell takes new data during a full append.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_entry <= i_wdata;
        end else if (i_ctrl.shift) begin
            r_entry <= i_nbr;
        end
    end

    assign o_entry = r_entry;
    assign o_eq    = (r_entry == i_cmp);
    assign o_alive = !i_check || i_mask[r_entry.buffer];

endmodule

### rtl/jump_history_stack.sv
// jump_history_stack: top level of the back/forward history of jump entries.
// Depends on jhs_pkg and jhs_cell.
//
// A command transaction is taken when start is high and busy is low; each
// command gives exactly one result, shown for a single cycle with o_strobe
// high, and the receiver cannot hold it off, so it must sample on that cycle.
// A push's result appears in the cycle after the start and busy stays low,
// so pushes may issue every cycle. A step older or newer walks the row of
// DEPTH cells one entry per cycle, testing each entry's buffer against the
// alive mask captured with the command (every entry counts as live when
// i_check_alive was low); it holds busy until a live entry is visited or the
// walk runs off the end without a hit, and the result strobes in the first
// cycle with busy low. History lives in a chain of DEPTH cells; when the
// history is full an append shifts every cell down by one at once, dropping
// the oldest entry. o_cursor and o_fill are valid with the strobe and give
// the low five bits of cursor and fill. A mode code of three changes nothing
// and reports not found. Cells hold no reset value; only cells below the
// fill count are ever read.
module jump_history_stack #(
    parameter int DEPTH = jhs_pkg::DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [jhs_pkg::MODE_W-1:0]    i_mode,
    input  logic [jhs_pkg::BUF_W-1:0]     i_entry_buffer,
    input  logic [jhs_pkg::POS_W-1:0]     i_entry_position,
    input  logic [jhs_pkg::MASK_W-1:0]    i_alive_mask,
    input  logic                          i_check_alive,
    output logic                          o_strobe,
    output logic                          o_found,
    output logic [jhs_pkg::BUF_W-1:0]     o_out_buffer,
    output logic [jhs_pkg::POS_W-1:0]     o_out_position,
    output logic [jhs_pkg::CNT_OUT_W-1:0] o_cursor,
    output logic [jhs_pkg::CNT_OUT_W-1:0] o_fill
);
    import jhs_pkg::*;

    localparam int PTR_W = $clog2(DEPTH + 1);   // holds 0..DEPTH
    localparam int IDX_W = $clog2(DEPTH);       // addresses one cell

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_OLDER = 3'b010,
        S_NEWER = 3'b100
    } t_state;

    // ---------------- state ----------------
    t_state             r_state,   n_state;
    logic [PTR_W-1:0]   r_pointer, n_pointer;
    logic [PTR_W-1:0]   r_used,    n_used;
    logic               r_strobe,  n_strobe;
    logic               r_found,   n_found;
    t_entry             r_hit,     n_hit;
    logic [MASK_W-1:0]  r_mask;
    logic               r_check;

    // ---------------- cell row ----------------
    t_entry             cell_entry [DEPTH];
    logic [DEPTH-1:0]   eq_vec;
    logic [DEPTH-1:0]   alive_vec;
    t_entry             in_entry;
    logic               wr_en;
    logic               shift_en;
    logic [IDX_W-1:0]   wr_idx;

    assign in_entry.buffer   = i_entry_buffer;
    assign in_entry.position = i_entry_position;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_cell_ctrl ctrl;
        t_entry     nbr;
        assign ctrl.load  = wr_en && (wr_idx == IDX_W'(g));
        assign ctrl.shift = shift_en;
        if (g == DEPTH - 1) begin : g_top
            assign nbr = in_entry;
        end else begin : g_mid
            assign nbr = cell_entry[g+1];
        end
        jhs_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (ctrl),
            .i_nbr   (nbr),
            .i_wdata (in_entry),
            .i_cmp   (in_entry),
            .i_mask  (r_mask),
            .i_check (r_check),
            .o_entry (cell_entry[g]),
            .o_eq    (eq_vec[g]),
            .o_alive (alive_vec[g])
        );
    end

    // ---------------- command decode helpers ----------------
    logic               accept;
    t_mode              mode;
    logic [PTR_W-1:0]   p_clamp;    // cursor bounded to fill
    logic [PTR_W-1:0]   app_base;   // fill level an append works from
    logic               dup;        // entry equals the last one kept
    logic               app_full;
    logic [IDX_W-1:0]   app_idx;
    logic [PTR_W-1:0]   app_used;
    logic [IDX_W-1:0]   old_idx;
    logic [PTR_W:0]     new_pos;

    assign accept = start && !busy;
    assign mode   = t_mode'(i_mode);

    always_comb begin
        p_clamp  = (r_pointer > r_used) ? r_used : r_pointer;
        // a push first cuts the forward part off at the cursor
        app_base = (mode == MODE_PUSH) ? p_clamp : r_used;
        dup      = (app_base != '0) && eq_vec[IDX_W'(app_base - 1'b1)];
        app_full = (app_base == PTR_W'(DEPTH));
        app_idx  = app_full ? IDX_W'(DEPTH - 1) : IDX_W'(app_base);
        app_used = app_full ? PTR_W'(DEPTH) : app_base + 1'b1;
        old_idx  = IDX_W'(r_pointer - 1'b1);
        new_pos  = {1'b0, r_pointer} + 1'b1;
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state   = r_state;
        n_pointer = r_pointer;
        n_used    = r_used;
        n_strobe  = 1'b0;
        n_found   = 1'b0;
        n_hit     = '0;
        wr_en     = 1'b0;
        shift_en  = 1'b0;
        wr_idx    = app_idx;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (mode)
                        MODE_PUSH: begin
                            n_strobe = 1'b1;
                            if (dup) begin
                                n_used    = p_clamp;
                                n_pointer = p_clamp;
                            end else begin
                                wr_en     = 1'b1;
                                shift_en  = app_full;
                                n_used    = app_used;
                                n_pointer = app_used;
                            end
                        end
                        MODE_OLDER: begin
                            n_state = S_OLDER;
                            if (p_clamp == r_used) begin
                                // at the live end: record where we are, stand on it
                                if (dup) begin
                                    n_pointer = r_used - 1'b1;
                                end else begin
                                    wr_en     = 1'b1;
                                    shift_en  = app_full;
                                    n_used    = app_used;
                                    n_pointer = app_used - 1'b1;
                                end
                            end else begin
                                n_pointer = p_clamp;
                            end
                        end
                        MODE_NEWER: begin
                            n_state   = S_NEWER;
                            n_pointer = p_clamp;
                        end
                        default: begin
                            n_pointer = p_clamp;
                            n_strobe  = 1'b1;
                        end
                    endcase
                end
            end
            S_OLDER: begin
                if (r_pointer == '0) begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_pointer = r_pointer - 1'b1;
                    if (alive_vec[old_idx]) begin
                        n_found  = 1'b1;
                        n_hit    = cell_entry[old_idx];
                        n_strobe = 1'b1;
                        n_state  = S_IDLE;
                    end
                end
            end
            S_NEWER: begin
                if (new_pos < {1'b0, r_used}) begin
                    n_pointer = PTR_W'(new_pos);
                    if (alive_vec[IDX_W'(new_pos)]) begin
                        n_found  = 1'b1;
                        n_hit    = cell_entry[IDX_W'(new_pos)];
                        n_strobe = 1'b1;
                        n_state  = S_IDLE;
                    end
                end else begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pointer <= '0;
            r_used    <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pointer <= n_pointer;
            r_used    <= n_used;
            r_strobe  <= n_strobe;
        end
    end

    // result payload and captured walk qualifiers
    always_ff @(posedge i_clk) begin
        r_found <= n_found;
        r_hit   <= n_hit;
        if (accept) begin
            r_mask  <= i_alive_mask;
            r_check <= i_check_alive;
        end
    end

    // ---------------- outputs ----------------
    assign busy           = (r_state != S_IDLE);
    assign o_strobe       = r_strobe;
    assign o_found        = r_found;
    assign o_out_buffer   = r_hit.buffer;
    assign o_out_position = r_hit.position;
    assign o_cursor       = CNT_OUT_W'(r_pointer);
    assign o_fill         = CNT_OUT_W'(r_used);

endmodule

### rtl/jhs_checker.sv
// jhs_checker: port-level checks for jump_history_stack, bound to the top.
// Depends on jhs_pkg.
module jhs_checker #(
    parameter int DEPTH = jhs_pkg::DEPTH_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [jhs_pkg::MODE_W-1:0]    i_mode,
    input logic                          o_strobe,
    input logic                          o_found,
    input logic [jhs_pkg::BUF_W-1:0]     o_out_buffer,
    input logic [jhs_pkg::POS_W-1:0]     o_out_position,
    input logic [jhs_pkg::CNT_OUT_W-1:0] o_cursor,
    input logic [jhs_pkg::CNT_OUT_W-1:0] o_fill
);
    import jhs_pkg::*;

    // a command either starts a walk or reports at once
    a_cmd_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_strobe))
        else $error("command neither walked nor reported");

    // a push always leaves the cursor at the live end and finds nothing
    a_push_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_mode == MODE_PUSH) |=>
            (o_strobe && !o_found && o_cursor == o_fill))
        else $error("push result wrong");

    // a miss carries a zero entry
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_found) |-> (o_out_buffer == '0 && o_out_position == '0))
        else $error("miss with nonzero entry");

    // a walk ends with a result in the first cycle with busy low
    a_walk_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe)
        else $error("walk ended without result");

    // the history never reports more entries than it has cells
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (int'(o_fill) <= DEPTH))
        else $error("fill beyond depth");

endmodule

bind jump_history_stack jhs_checker #(.DEPTH(DEPTH)) u_jhs_checker (.*);
